@@ rtl/pdu_pkg.sv @@
// pdu_pkg: shared widths, register codes, constants and types of the pid position drive
// no dependencies, compiled first

package pdu_pkg;

	// word field widths
	localparam int POS_W   = 16;
	localparam int CODE_W  = 8;
	localparam int DRIVE_W = 9;
	localparam int MAG_W   = 8;

	// configuration port
	localparam int GAIN_W  = 32;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_KP = 2'd0;
	localparam logic [IDX_W-1:0] REG_KI = 2'd1;
	localparam logic [IDX_W-1:0] REG_KD = 2'd2;

	// error path
	localparam int ERR_W     = 17;
	localparam int DIFF_W    = ERR_W + 1;
	// error sum holds +-250 * 2^frac, so frac + 9 bits signed
	localparam int SUM_EXTRA = 9;

	// derivative product saturates the drive at 2^40
	localparam int DLIM_BIT = 40;

	// weighted sum width, enough for frac bits up to 16
	localparam int NSUM_W = 60;

	// scaled magnitude before the divide by 500, below 255 * 500
	localparam int H_W = 17;

	// floor(x / 125) = (x * 33555) >> 22 for x below 2^15
	localparam int DIV125_MUL = 33555;
	localparam int DIV125_SH  = 22;
	localparam int DIV125_W   = 16;

	localparam logic [MAG_W-1:0]          MAG_FULL  = 8'd255;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 9'sd255;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -9'sd255;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} pdu_gains_t;

	typedef struct packed {
		logic sat_pos;
		logic sat_neg;
	} pdu_sat_t;

endpackage

@@ rtl/pdu_if.sv @@
// pdu_if: valid/ready channels for sample words and drive words
// depends on pdu_pkg for field widths

interface pdu_in_if;
	logic                            valid;
	logic                            ready;
	logic [pdu_pkg::POS_W-1:0]       position_sample;
	logic [pdu_pkg::CODE_W-1:0]      target_code;

	modport source (output valid, position_sample, target_code, input ready);
	modport sink (input valid, position_sample, target_code, output ready);
endinterface

interface pdu_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [pdu_pkg::DRIVE_W-1:0]  drive_value;
	logic                                drive_direction;
	logic [pdu_pkg::MAG_W-1:0]           drive_magnitude;

	modport source (output valid, drive_value, drive_direction, drive_magnitude, input ready);
	modport sink (input valid, drive_value, drive_direction, drive_magnitude, output ready);
endinterface

@@ rtl/pdu_apb.sv @@
// pdu_apb: apb-style register file holding the three pid gains
// depends on pdu_pkg

module pdu_apb (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pdu_pkg::PADDR_W-1:0]     paddr,
	input  logic [pdu_pkg::PDATA_W-1:0]     pwdata,
	output logic [pdu_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	output pdu_pkg::pdu_gains_t             gains
);

	pdu_pkg::pdu_gains_t            gains_q;
	logic                           wr_en;
	logic [pdu_pkg::IDX_W-1:0]      idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[pdu_pkg::PADDR_W-1:2];
	assign gains  = gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				pdu_pkg::REG_KP: begin
					gains_q.kp <= $signed(pwdata);
				end
				pdu_pkg::REG_KI: begin
					gains_q.ki <= $signed(pwdata);
				end
				pdu_pkg::REG_KD: begin
					gains_q.kd <= $signed(pwdata);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pdu_pkg::REG_KP: prdata = gains_q.kp;
			pdu_pkg::REG_KI: prdata = gains_q.ki;
			pdu_pkg::REG_KD: prdata = gains_q.kd;
			default:         prdata = '0;
		endcase
	end

endmodule

@@ rtl/pdu_front.sv @@
// pdu_front: target mapping, error, clamped error sum and derivative difference (s1..s5)
// depends on pdu_pkg

module pdu_front #(
	parameter int POSITION_FRAC_BITS = 14
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    up_valid,
	output logic                                                    up_ready,
	input  logic [pdu_pkg::POS_W-1:0]                               position_sample,
	input  logic [pdu_pkg::CODE_W-1:0]                              target_code,
	output logic                                                    dn_valid,
	input  logic                                                    dn_ready,
	output logic signed [pdu_pkg::ERR_W-1:0]                        err,
	output logic signed [POSITION_FRAC_BITS+pdu_pkg::SUM_EXTRA-1:0] err_sum,
	output logic signed [pdu_pkg::DIFF_W-1:0]                       err_diff
);

	localparam int    P          = POSITION_FRAC_BITS;
	localparam longint RELEASED_Q = ((longint'(108) << P) + 50) / 100;
	localparam longint SPAN_Q     = ((longint'(73) << P) + 50) / 100;
	localparam int    X_W        = P + 8;
	// reciprocal of 255, exact for any x below 2^X_W
	localparam int    RS         = X_W + 8;
	localparam longint RECIP      = ((longint'(1) << RS) + 254) / 255;
	localparam int    RECIP_W    = X_W + 1;
	localparam int    PR_W       = X_W + RECIP_W;
	localparam int    TGT_W      = P + 1;
	localparam int    TD_W       = ((TGT_W > pdu_pkg::POS_W) ? TGT_W : pdu_pkg::POS_W) + 1;
	localparam int    SUM_W      = P + pdu_pkg::SUM_EXTRA;
	localparam int    ERR_W      = pdu_pkg::ERR_W;
	localparam int    DIFF_W     = pdu_pkg::DIFF_W;

	localparam logic signed [TD_W-1:0]  ERR_HI = TD_W'((1 << (ERR_W - 1)) - 1);
	localparam logic signed [TD_W-1:0]  ERR_LO = ~ERR_HI;
	localparam logic signed [SUM_W:0]   LIM_HI = (SUM_W + 1)'(longint'(250) << P);
	localparam logic signed [SUM_W:0]   LIM_LO = -LIM_HI;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;

	// stage payloads
	logic [pdu_pkg::POS_W-1:0]   pos_s1, pos_s2, pos_s3;
	logic [pdu_pkg::CODE_W-1:0]  code_s1;
	logic [X_W-1:0]              x_s2;
	logic [TGT_W-1:0]            tgt_s3;
	logic signed [ERR_W-1:0]     err_s4, err_s5;
	logic signed [SUM_W-1:0]     sum_s5;
	logic signed [DIFF_W-1:0]    diff_s5;

	// loop state
	logic signed [SUM_W-1:0]     sum_q;
	logic signed [ERR_W-1:0]     last_q;

	logic [X_W-1:0]              x_next;
	logic [PR_W-1:0]             prod;
	logic [P-1:0]                quot;
	logic [TGT_W-1:0]            tgt_next;
	logic signed [TD_W-1:0]      td;
	logic signed [ERR_W-1:0]     err_next;
	logic signed [SUM_W:0]       sum_wide;
	logic signed [SUM_W-1:0]     sum_next;
	logic signed [DIFF_W-1:0]    diff_next;
	logic                        enter_s5;

	assign ld_s5    = !v_s5 || dn_ready;
	assign ld_s4    = !v_s4 || ld_s5;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign up_ready = ld_s1;
	assign enter_s5 = ld_s5 && v_s4;

	assign dn_valid = v_s5;
	assign err      = err_s5;
	assign err_sum  = sum_s5;
	assign err_diff = diff_s5;

	// code * span + half of 255
	assign x_next   = X_W'(code_s1) * X_W'(SPAN_Q) + X_W'(127);
	assign prod     = PR_W'(x_s2) * PR_W'(RECIP);
	assign quot     = prod[RS +: P];
	assign tgt_next = TGT_W'(RELEASED_Q) + TGT_W'(quot);

	assign td = $signed(TD_W'(tgt_s3)) - $signed(TD_W'(pos_s3));

	always_comb begin
		if (td > ERR_HI) begin
			err_next = $signed(ERR_HI[ERR_W-1:0]);
		end else if (td < ERR_LO) begin
			err_next = $signed(ERR_LO[ERR_W-1:0]);
		end else begin
			err_next = $signed(td[ERR_W-1:0]);
		end
	end

	assign sum_wide  = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(err_s4);
	assign diff_next = DIFF_W'(err_s4) - DIFF_W'(last_q);

	always_comb begin
		if (sum_wide > LIM_HI) begin
			sum_next = $signed(LIM_HI[SUM_W-1:0]);
		end else if (sum_wide < LIM_LO) begin
			sum_next = $signed(LIM_LO[SUM_W-1:0]);
		end else begin
			sum_next = $signed(sum_wide[SUM_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			sum_q  <= '0;
			last_q <= '0;
		end else begin
			if (ld_s1) v_s1 <= up_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
			if (enter_s5) begin
				sum_q  <= sum_next;
				last_q <= err_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			pos_s1  <= position_sample;
			code_s1 <= target_code;
		end
		if (ld_s2) begin
			pos_s2 <= pos_s1;
			x_s2   <= x_next;
		end
		if (ld_s3) begin
			pos_s3 <= pos_s2;
			tgt_s3 <= tgt_next;
		end
		if (ld_s4) begin
			err_s4 <= err_next;
		end
		if (ld_s5) begin
			err_s5  <= err_s4;
			sum_s5  <= sum_next;
			diff_s5 <= diff_next;
		end
	end

	// integral clamp holds at all times
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((SUM_W + 1)'(sum_q) <= LIM_HI) && ((SUM_W + 1)'(sum_q) >= LIM_LO))
		else $error("error sum outside clamp");

	// each word entering s5 leaves its error as the next derivative reference
	a_last_err: assert property (@(posedge clk) disable iff (!arst_n)
		enter_s5 |=> (last_q == $past(err_s4)) && (sum_s5 == sum_q))
		else $error("loop state not updated with word entering s5");

endmodule

@@ rtl/pdu_terms.sv @@
// pdu_terms: gain products and the weighted pid sum with derivative saturation flags (s6..s9)
// depends on pdu_pkg

module pdu_terms #(
	parameter int POSITION_FRAC_BITS = 14
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    up_valid,
	output logic                                                    up_ready,
	input  logic signed [pdu_pkg::ERR_W-1:0]                        err,
	input  logic signed [POSITION_FRAC_BITS+pdu_pkg::SUM_EXTRA-1:0] err_sum,
	input  logic signed [pdu_pkg::DIFF_W-1:0]                       err_diff,
	input  pdu_pkg::pdu_gains_t                                     gains,
	output logic                                                    dn_valid,
	input  logic                                                    dn_ready,
	output logic signed [pdu_pkg::NSUM_W-1:0]                       n_sum,
	output pdu_pkg::pdu_sat_t                                       dsat
);

	localparam int SUM_W = POSITION_FRAC_BITS + pdu_pkg::SUM_EXTRA;
	localparam int PP_W  = pdu_pkg::GAIN_W + pdu_pkg::ERR_W;
	localparam int IP_W  = pdu_pkg::GAIN_W + SUM_W;
	localparam int DP_W  = pdu_pkg::GAIN_W + pdu_pkg::DIFF_W;
	localparam int PT_W  = PP_W + 9;
	localparam int D1_W  = pdu_pkg::DLIM_BIT + 1 + 9;
	localparam int NW    = pdu_pkg::NSUM_W;

	localparam logic signed [DP_W-1:0] DLIM_POS = DP_W'(longint'(1) << pdu_pkg::DLIM_BIT);
	localparam logic signed [DP_W-1:0] DLIM_NEG = -DLIM_POS;

	logic v_s6, v_s7, v_s8, v_s9;
	logic ld_s6, ld_s7, ld_s8, ld_s9;

	logic signed [PP_W-1:0]   pp_s6;
	logic signed [IP_W-1:0]   ip_s6, ip_s7;
	logic signed [DP_W-1:0]   dp_s6;
	logic signed [PT_W-1:0]   pt_s7;
	logic signed [D1_W-1:0]   d1_s7;
	logic signed [NW-1:0]     d2_s8, pi_s8, n_s9;
	pdu_pkg::pdu_sat_t        sat_s7, sat_s8, sat_s9;

	logic signed [PT_W-1:0]   pe;
	logic signed [D1_W-1:0]   de;
	logic signed [NW-1:0]     d2e;
	pdu_pkg::pdu_sat_t        sat_next;

	assign ld_s9    = !v_s9 || dn_ready;
	assign ld_s8    = !v_s8 || ld_s9;
	assign ld_s7    = !v_s7 || ld_s8;
	assign ld_s6    = !v_s6 || ld_s7;
	assign up_ready = ld_s6;

	assign dn_valid = v_s9;
	assign n_sum    = n_s9;
	assign dsat     = sat_s9;

	// times 500 as 512 - 8 - 4
	assign pe  = PT_W'(pp_s6);
	assign de  = D1_W'($signed(dp_s6[pdu_pkg::DLIM_BIT:0]));
	assign d2e = NW'(d1_s7);

	assign sat_next.sat_pos = dp_s6 >= DLIM_POS;
	assign sat_next.sat_neg = dp_s6 <= DLIM_NEG;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (ld_s6) v_s6 <= up_valid;
			if (ld_s7) v_s7 <= v_s6;
			if (ld_s8) v_s8 <= v_s7;
			if (ld_s9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			pp_s6 <= PP_W'(gains.kp) * PP_W'(err);
			ip_s6 <= IP_W'(gains.ki) * IP_W'(err_sum);
			dp_s6 <= DP_W'(gains.kd) * DP_W'(err_diff);
		end
		if (ld_s7) begin
			pt_s7  <= (pe <<< 9) - (pe <<< 3) - (pe <<< 2);
			d1_s7  <= (de <<< 9) - (de <<< 3) - (de <<< 2);
			ip_s7  <= ip_s6;
			sat_s7 <= sat_next;
		end
		if (ld_s8) begin
			d2_s8  <= (d2e <<< 9) - (d2e <<< 3) - (d2e <<< 2);
			pi_s8  <= NW'(pt_s7) + NW'(ip_s7);
			sat_s8 <= sat_s7;
		end
		if (ld_s9) begin
			n_s9   <= pi_s8 + d2_s8;
			sat_s9 <= sat_s8;
		end
	end

endmodule

@@ rtl/pdu_out.sv @@
// pdu_out: output clamp, scale by 255 over full scale, and the drive output register (s10..s12)
// depends on pdu_pkg

module pdu_out #(
	parameter int POSITION_FRAC_BITS = 14,
	parameter int GAIN_FRAC_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  logic signed [pdu_pkg::NSUM_W-1:0]   n_sum,
	input  pdu_pkg::pdu_sat_t                   dsat,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output logic signed [pdu_pkg::DRIVE_W-1:0]  drive_value,
	output logic                                drive_direction,
	output logic [pdu_pkg::MAG_W-1:0]           drive_magnitude
);

	localparam int K      = POSITION_FRAC_BITS + GAIN_FRAC_BITS;
	localparam int NW     = pdu_pkg::NSUM_W;
	localparam int MAGK_W = K + 9;
	localparam int SC_W   = MAGK_W + 8;
	localparam int H_W    = pdu_pkg::H_W;
	localparam int QP_W   = H_W - 2 + pdu_pkg::DIV125_W;

	// full scale: 500 * 2^(gain frac + position frac)
	localparam logic signed [NW-1:0] T_POS = NW'(longint'(500) << K);
	localparam logic signed [NW-1:0] T_NEG = -T_POS;

	logic v_s10, v_s11, v_s12;
	logic ld_s10, ld_s11, ld_s12;

	logic [MAGK_W-1:0]                    mag_s10;
	logic                                 neg_s10, neg_s11;
	pdu_pkg::pdu_sat_t                    sat_s10, sat_s11;
	logic [H_W-1:0]                       h_s11;
	logic signed [pdu_pkg::DRIVE_W-1:0]   drive_s12;
	logic                                 dir_s12;
	logic [pdu_pkg::MAG_W-1:0]            mag_s12;

	logic [NW-1:0]                        nabs;
	pdu_pkg::pdu_sat_t                    sat_next;
	logic [SC_W-1:0]                      mp, sc;
	logic [QP_W-1:0]                      qp;
	logic [pdu_pkg::MAG_W-1:0]            q;
	logic signed [pdu_pkg::DRIVE_W-1:0]   qs;
	logic signed [pdu_pkg::DRIVE_W-1:0]   drive_next;
	logic                                 dir_next;
	logic [pdu_pkg::MAG_W-1:0]            mag_next;

	assign ld_s12   = !v_s12 || dn_ready;
	assign ld_s11   = !v_s11 || ld_s12;
	assign ld_s10   = !v_s10 || ld_s11;
	assign up_ready = ld_s10;

	assign dn_valid        = v_s12;
	assign drive_value     = drive_s12;
	assign drive_direction = dir_s12;
	assign drive_magnitude = mag_s12;

	// derivative saturation wins over the clamp of the sum
	assign sat_next.sat_pos = dsat.sat_pos || (!dsat.sat_neg && (n_sum >= T_POS));
	assign sat_next.sat_neg = !dsat.sat_pos && (dsat.sat_neg || (n_sum <= T_NEG));
	assign nabs = n_sum[NW-1] ? NW'(-n_sum) : NW'(n_sum);

	// floor(|n| * 255 / 2^K), below 255 * 500 when unclamped
	assign mp = SC_W'(mag_s10);
	assign sc = (mp << 8) - mp;

	// floor(h / 500) as floor((h / 4) / 125)
	assign qp = QP_W'(h_s11[H_W-1:2]) * QP_W'(pdu_pkg::DIV125_MUL);
	assign q  = qp[pdu_pkg::DIV125_SH +: pdu_pkg::MAG_W];
	assign qs = $signed({1'b0, q});

	always_comb begin
		if (sat_s11.sat_pos) begin
			drive_next = pdu_pkg::DRIVE_MAX;
			mag_next   = pdu_pkg::MAG_FULL;
			dir_next   = 1'b0;
		end else if (sat_s11.sat_neg) begin
			drive_next = pdu_pkg::DRIVE_MIN;
			mag_next   = pdu_pkg::MAG_FULL;
			dir_next   = 1'b1;
		end else begin
			drive_next = neg_s11 ? -qs : qs;
			mag_next   = q;
			dir_next   = neg_s11 || (q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (ld_s10) v_s10 <= up_valid;
			if (ld_s11) v_s11 <= v_s10;
			if (ld_s12) v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s10) begin
			mag_s10 <= nabs[MAGK_W-1:0];
			neg_s10 <= n_sum[NW-1];
			sat_s10 <= sat_next;
		end
		if (ld_s11) begin
			h_s11   <= sc[K +: H_W];
			neg_s11 <= neg_s10;
			sat_s11 <= sat_s10;
		end
		if (ld_s12) begin
			drive_s12 <= drive_next;
			dir_s12   <= dir_next;
			mag_s12   <= mag_next;
		end
	end

	a_sat_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 |-> !(sat_s10.sat_pos && sat_s10.sat_neg))
		else $error("both clamp directions set");

	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		v_s12 |-> (dir_s12 == (drive_s12 <= 0)))
		else $error("direction disagrees with drive value");

	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s12 |-> ((drive_s12 < 0) ? (-drive_s12 == $signed({1'b0, mag_s12}))
			: (drive_s12 == $signed({1'b0, mag_s12}))))
		else $error("magnitude disagrees with drive value");

endmodule

@@ rtl/pid_position_drive_unit.sv @@
// pid_position_drive_unit: top level of the pid position drive
// depends on pdu_pkg, pdu_if, pdu_apb, pdu_front, pdu_terms, pdu_out
// a sample word passes twelve register stages, s1..s12, before its drive word is offered
// throughput: one word per cycle while the drive channel is ready, the error sum and last
// error close their loop in one stage
// every stage holds its word only while the next stage is full and stalled, bubbles fold up
// reset: arst_n clears all stage valids, the gains, the error sum and the last error at once

module pid_position_drive_unit #(
	parameter int POSITION_FRAC_BITS = 14,
	parameter int GAIN_FRAC_BITS     = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pdu_in_if.sink                          sample,
	pdu_out_if.source                       drive,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pdu_pkg::PADDR_W-1:0]     paddr,
	input  logic [pdu_pkg::PDATA_W-1:0]     pwdata,
	output logic [pdu_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int SUM_W = POSITION_FRAC_BITS + pdu_pkg::SUM_EXTRA;

	pdu_pkg::pdu_gains_t                  gains;

	// front end to terms
	logic                                 fe_valid, fe_ready;
	logic signed [pdu_pkg::ERR_W-1:0]     fe_err;
	logic signed [SUM_W-1:0]              fe_sum;
	logic signed [pdu_pkg::DIFF_W-1:0]    fe_diff;

	// terms to output stage
	logic                                 tm_valid, tm_ready;
	logic signed [pdu_pkg::NSUM_W-1:0]    tm_n;
	pdu_pkg::pdu_sat_t                    tm_sat;

	// gains, to be written only while the pipeline is empty; the block itself does not enforce it
	pdu_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	// s1..s5: target voltage, error, clamped integral and derivative difference
	pdu_front #(
		.POSITION_FRAC_BITS (POSITION_FRAC_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.up_valid        (sample.valid),
		.up_ready        (sample.ready),
		.position_sample (sample.position_sample),
		.target_code     (sample.target_code),
		.dn_valid        (fe_valid),
		.dn_ready        (fe_ready),
		.err             (fe_err),
		.err_sum         (fe_sum),
		.err_diff        (fe_diff)
	);

	// s6..s9: gain products, scaling by 500 and 250000, weighted sum
	pdu_terms #(
		.POSITION_FRAC_BITS (POSITION_FRAC_BITS)
	) u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (fe_valid),
		.up_ready (fe_ready),
		.err      (fe_err),
		.err_sum  (fe_sum),
		.err_diff (fe_diff),
		.gains    (gains),
		.dn_valid (tm_valid),
		.dn_ready (tm_ready),
		.n_sum    (tm_n),
		.dsat     (tm_sat)
	);

	// s10..s12: clamp to full scale, scale to +-255, output register
	pdu_out #(
		.POSITION_FRAC_BITS (POSITION_FRAC_BITS),
		.GAIN_FRAC_BITS     (GAIN_FRAC_BITS)
	) u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.up_valid        (tm_valid),
		.up_ready        (tm_ready),
		.n_sum           (tm_n),
		.dsat            (tm_sat),
		.dn_valid        (drive.valid),
		.dn_ready        (drive.ready),
		.drive_value     (drive.drive_value),
		.drive_direction (drive.drive_direction),
		.drive_magnitude (drive.drive_magnitude)
	);

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for pid_position_drive_unit, sample words in, drive words out
// depends on pdu_pkg and pdu_if from the rtl folder, plus the unit itself

module tb;

	// fixed-point set-up the unit is built with
	localparam int POS_FRAC  = 14;
	localparam int GAIN_FRAC = 16;

	// released level and span of the target map, 1.08 V and 0.73 V in voltage lsbs
	localparam longint RELEASED_LVL = ((longint'(108) << POS_FRAC) + 50) / 100;
	localparam longint SPAN_LVL     = ((longint'(73) << POS_FRAC) + 50) / 100;
	// error sum limit, 0.5 V*s at a 2 ms tick
	localparam longint SUM_LIMIT    = 250 * (longint'(1) << POS_FRAC);
	// full scale of the weighted sum, i.e. an output of exactly 1.0
	localparam longint FULL_SCALE   = 500 * (longint'(1) << (GAIN_FRAC + POS_FRAC));
	localparam longint DTERM_LIM    = longint'(1) << pdu_pkg::DLIM_BIT;
	localparam longint ERR_HI       = 65535;
	localparam longint ERR_LO       = -65536;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 24;

	typedef struct packed {
		logic [pdu_pkg::POS_W-1:0]  pos;
		logic [pdu_pkg::CODE_W-1:0] code;
	} sample_word_t;

	typedef struct packed {
		logic signed [pdu_pkg::DRIVE_W-1:0] value;
		logic                               dir;
		logic [pdu_pkg::MAG_W-1:0]          mag;
	} drive_word_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [pdu_pkg::PADDR_W-1:0] paddr;
	logic [pdu_pkg::PDATA_W-1:0] pwdata;
	logic [pdu_pkg::PDATA_W-1:0] prdata;
	logic pready;

	pdu_in_if  sample_ch ();
	pdu_out_if drive_ch ();

	pid_position_drive_unit #(
		.POSITION_FRAC_BITS(POS_FRAC),
		.GAIN_FRAC_BITS(GAIN_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.drive(drive_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// words waiting to be sent, and drive words owed by the unit
	sample_word_t pending_samples[$];
	drive_word_t  expected_drives[$];

	// controller state as the bench sees it
	longint gain_kp, gain_ki, gain_kd;
	longint error_sum;
	longint last_error;

	// idle chances in percent, changed between phases
	int sender_idle_pct;
	int receiver_idle_pct;

	int mismatch_count;
	int drive_count;
	int cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at drive word %0d: %s", drive_count, msg);
		mismatch_count++;
	endtask

	// target voltage of a code, rounded half up onto the voltage lsb
	function automatic longint target_level(input logic [pdu_pkg::CODE_W-1:0] code);
		longint c;
		c = longint'(code);
		return RELEASED_LVL + (c * SPAN_LVL + 127) / 255;
	endfunction

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// one controller tick: updates error sum and last error, returns the drive word
	function automatic drive_word_t predict_drive(input logic [pdu_pkg::POS_W-1:0] pos,
			input logic [pdu_pkg::CODE_W-1:0] code);
		longint p, err, diff, dprod, n, mag, drv;
		drive_word_t w;
		p = longint'(pos);
		err = clamp_to(target_level(code) - p, ERR_LO, ERR_HI);
		diff = err - last_error;
		error_sum = clamp_to(error_sum + err, -SUM_LIMIT, SUM_LIMIT);
		last_error = err;
		dprod = gain_kd * diff;
		if (dprod >= DTERM_LIM) begin
			// derivative alone swamps everything else
			drv = 255;
		end else if (dprod <= -DTERM_LIM) begin
			drv = -255;
		end else begin
			n = 500 * gain_kp * err + gain_ki * error_sum + 250000 * dprod;
			if (n >= FULL_SCALE) begin
				drv = 255;
			end else if (n <= -FULL_SCALE) begin
				drv = -255;
			end else begin
				// scale by 255 and truncate toward zero
				mag = (n < 0) ? -n : n;
				mag = (mag * 255) / FULL_SCALE;
				drv = (n < 0) ? -mag : mag;
			end
		end
		w.value = drv[pdu_pkg::DRIVE_W-1:0];
		w.dir   = (drv <= 0);
		w.mag   = (drv < 0) ? pdu_pkg::MAG_W'(-drv) : pdu_pkg::MAG_W'(drv);
		return w;
	endfunction

	// driver: holds a word until it is taken, idles at random between words
	always @(posedge clk) begin
		sample_word_t w;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_drives.push_back(predict_drive(sample_ch.position_sample,
					sample_ch.target_code));
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (pending_samples.size() != 0 &&
						$urandom_range(0, 99) >= sender_idle_pct) begin
					w = pending_samples.pop_front();
					sample_ch.valid           <= 1'b1;
					sample_ch.position_sample <= w.pos;
					sample_ch.target_code     <= w.code;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each drive word against the oldest prediction, stalls at random
	always @(posedge clk) begin
		drive_word_t want;
		if (arst_n) begin
			if (drive_ch.valid && drive_ch.ready) begin
				if (expected_drives.size() == 0) begin
					report_mismatch($sformatf("unexpected drive word, value %0d",
						drive_ch.drive_value));
				end else begin
					want = expected_drives.pop_front();
					if (drive_ch.drive_value !== want.value)
						report_mismatch($sformatf("drive_value got %0d want %0d",
							drive_ch.drive_value, want.value));
					if (drive_ch.drive_direction !== want.dir)
						report_mismatch($sformatf("drive_direction got %b want %b",
							drive_ch.drive_direction, want.dir));
					if (drive_ch.drive_magnitude !== want.mag)
						report_mismatch($sformatf("drive_magnitude got %0d want %0d",
							drive_ch.drive_magnitude, want.mag));
				end
				drive_count++;
			end
			drive_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL pid_position_drive_unit");
			$finish;
		end
	end

	// wait until every queued word is sent and every drive word is back
	task automatic drain;
		while (pending_samples.size() != 0 || sample_ch.valid || expected_drives.size() != 0)
			@(posedge clk);
	endtask

	// apb write of one gain, then read it back
	task automatic set_gain(input logic [pdu_pkg::IDX_W-1:0] idx,
			input logic signed [pdu_pkg::GAIN_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands here, turn straight into a read of the same register
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value)
			report_mismatch($sformatf("gain register %0d read %h want %h", idx, prdata, value));
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			pdu_pkg::REG_KP: gain_kp = value;
			pdu_pkg::REG_KI: gain_ki = value;
			pdu_pkg::REG_KD: gain_kd = value;
			default: ;
		endcase
	endtask

	// gains only move while the unit is empty
	task automatic set_gains(input logic signed [pdu_pkg::GAIN_W-1:0] kp,
			input logic signed [pdu_pkg::GAIN_W-1:0] ki,
			input logic signed [pdu_pkg::GAIN_W-1:0] kd);
		drain();
		set_gain(pdu_pkg::REG_KP, kp);
		set_gain(pdu_pkg::REG_KI, ki);
		set_gain(pdu_pkg::REG_KD, kd);
	endtask

	function automatic logic signed [pdu_pkg::GAIN_W-1:0] rand_gain(input int span);
		int v;
		v = $urandom_range(0, span);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic push_sample(input longint pos, input logic [pdu_pkg::CODE_W-1:0] code);
		sample_word_t w;
		w.pos  = pdu_pkg::POS_W'(clamp_to(pos, 0, 65535));
		w.code = code;
		pending_samples.push_back(w);
	endtask

	// one random word; lean > 0 winds the error sum up, lean < 0 winds it down
	task automatic push_random_sample(input int lean);
		int r;
		int offset;
		logic [pdu_pkg::CODE_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			// plain noise over the full field ranges
			push_sample(longint'($urandom_range(0, 65535)),
				pdu_pkg::CODE_W'($urandom_range(0, 255)));
		end else if (lean > 0 && r < 85) begin
			push_sample(longint'($urandom_range(0, 1500)),
				pdu_pkg::CODE_W'($urandom_range(192, 255)));
		end else if (lean < 0 && r < 85) begin
			push_sample(longint'($urandom_range(50000, 65535)),
				pdu_pkg::CODE_W'($urandom_range(0, 63)));
		end else begin
			// near the target, where the drive is off the rails less often
			c = pdu_pkg::CODE_W'($urandom_range(0, 255));
			offset = (r & 1) ? $urandom_range(0, 300) : $urandom_range(0, 4000);
			if ($urandom_range(0, 1))
				offset = -offset;
			push_sample(target_level(c) + offset, c);
		end
	endtask

	initial begin
		int lean_of_phase[10];
		int n_words;
		lean_of_phase = '{1, 1, 1, -1, -1, -1, -1, 0, 0, 0};
		n_words = 83;

		// every input known from the first instant
		arst_n                    = 1'b0;
		sample_ch.valid           = 1'b0;
		sample_ch.position_sample = '0;
		sample_ch.target_code     = '0;
		drive_ch.ready            = 1'b0;
		psel                      = 1'b0;
		penable                   = 1'b0;
		pwrite                    = 1'b0;
		paddr                     = '0;
		pwdata                    = '0;
		gain_kp                   = 0;
		gain_ki                   = 0;
		gain_kd                   = 0;
		error_sum                 = 0;
		last_error                = 0;
		mismatch_count            = 0;
		drive_count               = 0;
		cycle_count               = 0;
		sender_idle_pct           = 28;
		receiver_idle_pct         = 74;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// moderate gains; the first word after reset sees a zero last error
		set_gains(32'sd65536, 32'sd131072, 32'sd131);
		push_sample(0, 8'd0);
		push_sample(65535, 8'd255);
		push_sample(16'h5555, 8'hAA);
		push_sample(16'hAAAA, 8'h55);
		push_sample(target_level(8'd128), 8'd128);
		push_sample(RELEASED_LVL, 8'd0);
		push_sample(RELEASED_LVL + SPAN_LVL, 8'd255);
		push_sample(RELEASED_LVL + 100, 8'd0);

		// extreme gains, large derivative swings either way
		set_gains(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
		push_sample(0, 8'd255);
		push_sample(65535, 8'd0);
		push_sample(target_level(8'd7), 8'd7);
		push_sample(target_level(8'd7), 8'd7);

		set_gains(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
		push_sample(0, 8'd255);
		push_sample(65535, 8'd0);
		push_sample(target_level(8'd7), 8'd7);
		push_sample(target_level(8'd7), 8'd7);

		// all gains zero gives a zero drive
		set_gains(32'sd0, 32'sd0, 32'sd0);
		push_sample(0, 8'd255);
		push_sample(65535, 8'd0);

		// derivative only, stepping over, then just under, then again over the saturation product
		set_gains(32'sd0, 32'sd0, 32'sd16777216);
		push_sample(0, 8'd255);
		push_sample(65535, 8'd255);
		push_sample(65535, 8'd0);
		push_sample(0, 8'd255);

		// random phases: gains change between phases, the error sum carries across
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 9)
				set_gains($signed($urandom()), $signed($urandom()), $signed($urandom()));
			else
				set_gains(rand_gain(131072), rand_gain(262144), rand_gain(400));
			if (ph < 4) begin
				sender_idle_pct   = 28;
				receiver_idle_pct = 74;
			end else if (ph < 7) begin
				sender_idle_pct   = 74;
				receiver_idle_pct = 28;
			end else begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
			for (int k = 0; k < n_words; k++) begin
				// let the pipe run dry once mid-phase before carrying on
				if (ph == 5 && k == n_words / 2)
					drain();
				push_random_sample(lean_of_phase[ph]);
			end
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS pid_position_drive_unit");
		end else begin
			$display("FAIL pid_position_drive_unit");
		end
		$finish;
	end

endmodule
